// ----- rtl/asbc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// asbc_pkg
// Shared constants of the adaptive step budget controller.
// ----------------------------------------------------------------------------
package asbc_pkg;

   localparam int HISTORY_DEPTH_DEF = 8;
   localparam int STEP_BITS_DEF     = 24;
   localparam int TIME_BITS_DEF     = 40;

   // fraction bits of the time-per-step figure
   localparam int FRAC_BITS = 8;

   // weights in tenths: 1.1 over budget, 0.9 under budget
   localparam int K_OVER  = 11;
   localparam int K_UNDER = 9;
   localparam int K_DEN   = 10;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_END   = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/asbc_hist_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// asbc_hist_mem
// Run history ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module asbc_hist_mem #(
   parameter int DEPTH = asbc_pkg::HISTORY_DEPTH_DEF,
   parameter int AW    = 3,
   parameter int WW    = 112
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [WW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [WW-1:0] rd_data
);

   logic [WW-1:0] mem_ff [DEPTH];
   logic [WW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/asbc_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// asbc_divider
// Restoring unsigned divider, one quotient bit per cycle; done pulses once.
// ----------------------------------------------------------------------------
module asbc_divider #(
   parameter int DW = 56
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic      [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [DW:0]   shifted;
   logic          ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(shifted - {1'b0, dvs_ff}) : shifted[DW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- rtl/adaptive_step_budget_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_step_budget_controller
// Picks the step count of the next run from the recorded run history and
// records measured runs in a ring.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  req     | in        | req_valid/req_ready, command, limit, desired, elapsed
//  rsp     | out       | rsp_valid/rsp_ready, step_count, ns_per_step_q8
//
// One transaction at a time. Run start with history: a walk of n history
// reads, then four serial divisions of DW bits (DW = 52 at defaults), three
// when the average time per step is zero. Run end: one division; none with a
// zero step count. Run start with empty history: no division. The shared
// bit-serial divider serves all of these. Synchronous reset clears control
// state only; the history memory holds no reset value and is read only below
// the fill count.
// The result sits in an output register, so a new request is taken while a
// finished result still waits for rsp_ready.
// ----------------------------------------------------------------------------
module adaptive_step_budget_controller #(
   parameter int HISTORY_DEPTH = asbc_pkg::HISTORY_DEPTH_DEF,
   parameter int STEP_BITS     = asbc_pkg::STEP_BITS_DEF,
   parameter int TIME_BITS     = asbc_pkg::TIME_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_command,
   input  wire logic [TIME_BITS-1:0]   req_time_limit_ns,
   input  wire logic [STEP_BITS-1:0]   req_desired_steps,
   input  wire logic [TIME_BITS-1:0]   req_elapsed_ns,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [STEP_BITS-1:0]        rsp_step_count,
   output logic [TIME_BITS+asbc_pkg::FRAC_BITS-1:0] rsp_ns_per_step_q8
);

   localparam int FB  = asbc_pkg::FRAC_BITS;
   localparam int PW  = TIME_BITS + FB;
   localparam int NB  = $clog2(HISTORY_DEPTH + 1);
   localparam int AW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int EW  = (NB > 4) ? NB : 4;
   localparam int DW  = PW + EW;
   localparam int VW  = DW + 1;
   localparam int WW  = STEP_BITS + TIME_BITS + PW;
   localparam int SSW = STEP_BITS + NB;
   localparam int SEW = TIME_BITS + NB;
   localparam int SPW = PW + NB;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_END_DIV  = 4'd1;
   localparam logic [3:0] ST_END_WR   = 4'd2;
   localparam logic [3:0] ST_WALK     = 4'd3;
   localparam logic [3:0] ST_DIV_S    = 4'd4;
   localparam logic [3:0] ST_DIV_E    = 4'd5;
   localparam logic [3:0] ST_DIV_P    = 4'd6;
   localparam logic [3:0] ST_CORR_SET = 4'd7;
   localparam logic [3:0] ST_CORR_GO  = 4'd8;
   localparam logic [3:0] ST_CORR_DIV = 4'd9;
   localparam logic [3:0] ST_FINAL    = 4'd10;
   localparam logic [3:0] ST_DONE     = 4'd11;

   logic [3:0]           state_ff, state_in;
   logic [NB-1:0]        count_ff, count_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [STEP_BITS-1:0] cur_ff, cur_in;
   logic [NB-1:0]        issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [TIME_BITS-1:0] limit_ff, limit_in;
   logic [STEP_BITS-1:0] desired_ff, desired_in;
   logic [TIME_BITS-1:0] el_ff, el_in;
   logic [SSW-1:0]       sum_s_ff, sum_s_in;
   logic [SEW-1:0]       sum_e_ff, sum_e_in;
   logic [SPW-1:0]       sum_p_ff, sum_p_in;
   logic [STEP_BITS-1:0] avg_s_ff, avg_s_in;
   logic [TIME_BITS-1:0] avg_e_ff, avg_e_in;
   logic [PW-1:0]        avg_p_ff, avg_p_in;
   logic                 over_ff, over_in;
   logic                 under_ff, under_in;
   logic [DW-1:0]        num_ff, num_in;
   logic [DW-1:0]        den_ff, den_in;
   logic [DW-1:0]        corr_ff, corr_in;
   logic                 inf_ff, inf_in;
   logic [STEP_BITS-1:0] res_ff, res_in;
   logic [PW-1:0]        ps_ff, ps_in;
   logic [STEP_BITS-1:0] rsp_sc_ff, rsp_sc_in;
   logic [PW-1:0]        rsp_ps_ff, rsp_ps_in;

   logic                 div_start;
   logic [DW-1:0]        div_num, div_den;
   logic                 div_done;
   logic [DW-1:0]        div_q;

   logic                 mem_we, mem_re;
   logic [WW-1:0]        mem_rd;
   logic [STEP_BITS-1:0] rd_steps;
   logic [TIME_BITS-1:0] rd_el;
   logic [PW-1:0]        rd_ps;
   logic [TIME_BITS-1:0] mag;
   logic [VW-1:0]        v;

   assign rd_steps = mem_rd[WW-1 -: STEP_BITS];
   assign rd_el    = mem_rd[PW +: TIME_BITS];
   assign rd_ps    = mem_rd[PW-1:0];

   asbc_hist_mem #(
      .DEPTH (HISTORY_DEPTH),
      .AW    (AW),
      .WW    (WW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (head_ff),
      .wr_data ({cur_ff, el_ff, ps_ff}),
      .rd_en   (mem_re),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (mem_rd)
   );

   asbc_divider #(
      .DW (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      limit_in     = limit_ff;
      desired_in   = desired_ff;
      el_in        = el_ff;
      sum_s_in     = sum_s_ff;
      sum_e_in     = sum_e_ff;
      sum_p_in     = sum_p_ff;
      avg_s_in     = avg_s_ff;
      avg_e_in     = avg_e_ff;
      avg_p_in     = avg_p_ff;
      over_in      = over_ff;
      under_in     = under_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      corr_in      = corr_ff;
      inf_in       = inf_ff;
      res_in       = res_ff;
      ps_in        = ps_ff;
      rsp_sc_in    = rsp_sc_ff;
      rsp_ps_in    = rsp_ps_ff;
      div_start    = 1'b0;
      div_num      = DW'(sum_s_ff);
      div_den      = DW'(count_ff);
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mag          = over_ff ? (avg_e_ff - limit_ff) : (limit_ff - avg_e_ff);
      v            = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               limit_in   = req_time_limit_ns;
               desired_in = req_desired_steps;
               el_in      = req_elapsed_ns;
               if (req_command == asbc_pkg::CMD_END) begin
                  if (cur_ff == '0) begin
                     ps_in    = '1;
                     state_in = ST_END_WR;
                  end else begin
                     div_start = 1'b1;
                     div_num   = DW'({req_elapsed_ns, {FB{1'b0}}});
                     div_den   = DW'(cur_ff);
                     state_in  = ST_END_DIV;
                  end
               end else if (count_ff == '0) begin
                  // empty history: fixed answer, no clamp
                  res_in   = STEP_BITS'(1);
                  cur_in   = STEP_BITS'(1);
                  ps_in    = '0;
                  state_in = ST_DONE;
               end else begin
                  issue_in = '0;
                  sum_s_in = '0;
                  sum_e_in = '0;
                  sum_p_in = '0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_END_DIV: begin
            if (div_done) begin
               ps_in    = div_q[PW-1:0];
               state_in = ST_END_WR;
            end
         end
         ST_END_WR: begin
            mem_we   = 1'b1;
            head_in  = (head_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : head_ff + AW'(1);
            count_in = (count_ff == NB'(HISTORY_DEPTH)) ? count_ff : count_ff + NB'(1);
            res_in   = cur_ff;
            state_in = ST_DONE;
         end
         ST_WALK: begin
            if (issue_ff != count_ff) begin
               mem_re   = 1'b1;
               pend_in  = 1'b1;
               issue_in = issue_ff + NB'(1);
            end
            if (pend_ff) begin
               sum_s_in = sum_s_ff + SSW'(rd_steps);
               sum_e_in = sum_e_ff + SEW'(rd_el);
               sum_p_in = sum_p_ff + SPW'(rd_ps);
            end else if (issue_ff == count_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV_S;
            end
         end
         ST_DIV_S: begin
            if (div_done) begin
               avg_s_in  = div_q[STEP_BITS-1:0];
               div_start = 1'b1;
               div_num   = DW'(sum_e_ff);
               state_in  = ST_DIV_E;
            end
         end
         ST_DIV_E: begin
            if (div_done) begin
               avg_e_in  = div_q[TIME_BITS-1:0];
               div_start = 1'b1;
               div_num   = DW'(sum_p_ff);
               state_in  = ST_DIV_P;
            end
         end
         ST_DIV_P: begin
            if (div_done) begin
               avg_p_in = div_q[PW-1:0];
               over_in  = avg_e_ff > limit_ff;
               under_in = avg_e_ff < limit_ff;
               state_in = ST_CORR_SET;
            end
         end
         ST_CORR_SET: begin
            // weighted numerator and tenfold denominator, constant multiplies
            num_in   = DW'({mag, {FB{1'b0}}}) *
                       (over_ff ? DW'(asbc_pkg::K_OVER) : DW'(asbc_pkg::K_UNDER));
            den_in   = DW'(avg_p_ff) * DW'(asbc_pkg::K_DEN);
            inf_in   = (avg_p_ff == '0);
            state_in = ST_CORR_GO;
         end
         ST_CORR_GO: begin
            if (inf_ff) begin
               corr_in  = '0;
               state_in = ST_FINAL;
            end else begin
               div_start = 1'b1;
               div_num   = num_ff;
               div_den   = den_ff;
               state_in  = ST_CORR_DIV;
            end
         end
         ST_CORR_DIV: begin
            if (div_done) begin
               corr_in  = div_q;
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (inf_ff && over_ff) begin
               v = VW'(1);
            end else if (inf_ff && under_ff) begin
               v = VW'(desired_ff);
            end else if (over_ff) begin
               v = (corr_ff >= DW'(avg_s_ff)) ? VW'(1) : VW'(avg_s_ff) - VW'(corr_ff);
            end else begin
               v = VW'(avg_s_ff) + VW'(corr_ff);
               if (v == '0) begin
                  v = VW'(1);
               end
            end
            res_in   = (v > VW'(desired_ff)) ? desired_ff : v[STEP_BITS-1:0];
            cur_in   = res_in;
            ps_in    = '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sc_in    = res_ff;
               rsp_ps_in    = ps_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         cur_ff       <= STEP_BITS'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         cur_ff       <= cur_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff   <= issue_in;
      limit_ff   <= limit_in;
      desired_ff <= desired_in;
      el_ff      <= el_in;
      sum_s_ff   <= sum_s_in;
      sum_e_ff   <= sum_e_in;
      sum_p_ff   <= sum_p_in;
      avg_s_ff   <= avg_s_in;
      avg_e_ff   <= avg_e_in;
      avg_p_ff   <= avg_p_in;
      over_ff    <= over_in;
      under_ff   <= under_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      corr_ff    <= corr_in;
      inf_ff     <= inf_in;
      res_ff     <= res_in;
      ps_ff      <= ps_in;
      rsp_sc_ff  <= rsp_sc_in;
      rsp_ps_ff  <= rsp_ps_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_count     = rsp_sc_ff;
   assign rsp_ns_per_step_q8 = rsp_ps_ff;

endmodule
`default_nettype wire

// ----- rtl/asbc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// asbc_checker
// Port-level checks of the step budget controller, bound to the top level.
// ----------------------------------------------------------------------------
module asbc_checker #(
   parameter int STEP_BITS = asbc_pkg::STEP_BITS_DEF,
   parameter int PW        = asbc_pkg::TIME_BITS_DEF + asbc_pkg::FRAC_BITS
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [STEP_BITS-1:0] rsp_step_count,
   input wire logic [PW-1:0]        rsp_ns_per_step_q8
);

   // transactions taken in but not yet delivered
   logic [1:0] open_ff, open_in;

   always_comb begin
      open_in = open_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_count)
                                   && $stable(rsp_ns_per_step_q8))
      else $error("result changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("result without a request");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("too many transactions in flight");

endmodule

bind adaptive_step_budget_controller asbc_checker #(
   .STEP_BITS (STEP_BITS),
   .PW        (TIME_BITS + asbc_pkg::FRAC_BITS)
) u_asbc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_step_count     (rsp_step_count),
   .rsp_ns_per_step_q8 (rsp_ns_per_step_q8)
);
`default_nettype wire
